// ----- rtl/iase_pkg.sv -----
// shared types and constants of the infix add/sub evaluator
package iase_pkg;

  localparam int unsigned StackDepth = 32;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CharW      = 8;
  localparam int unsigned OutValueW  = 32;
  localparam int unsigned ErrW       = 3;
  localparam int unsigned OpW        = 2;
  localparam int unsigned ClassW     = 2;

  localparam logic [ValueWidth-1:0] VSign = {1'b1, {(ValueWidth - 1){1'b0}}};
  localparam logic [ValueWidth-1:0] VMax  = ~VSign;

  typedef logic [OpW-1:0]    op_t;
  typedef logic [ClassW-1:0] class_t;
  typedef logic [ErrW-1:0]   err_t;
  typedef logic [CharW-1:0]  char_t;

  localparam op_t OpOpen = 2'd1;
  localparam op_t OpAdd  = 2'd2;
  localparam op_t OpSub  = 2'd3;

  localparam class_t ClsStart = 2'd0;
  localparam class_t ClsDigit = 2'd1;
  localparam class_t ClsParen = 2'd2;
  localparam class_t ClsOther = 2'd3;

  localparam err_t ErrNone      = 3'd0;
  localparam err_t ErrUnderflow = 3'd1;
  localparam err_t ErrOverflow  = 3'd2;
  localparam err_t ErrMulDiv    = 3'd3;
  localparam err_t ErrUnmatched = 3'd4;
  localparam err_t ErrNumber    = 3'd5;

  localparam char_t ChOpen  = 8'h28;
  localparam char_t ChClose = 8'h29;
  localparam char_t ChTimes = 8'h2a;
  localparam char_t ChPlus  = 8'h2b;
  localparam char_t ChMinus = 8'h2d;
  localparam char_t ChSlash = 8'h2f;
  localparam char_t ChZero  = 8'h30;
  localparam char_t ChNine  = 8'h39;

  typedef struct packed {
    char_t character;
    logic  last;
  } char_item_t;

  typedef struct packed {
    logic signed [OutValueW-1:0] value;
    err_t                        error;
  } result_item_t;

endpackage

// ----- rtl/iase_stream_if.sv -----
// valid/ready channel interfaces for characters and results
interface iase_char_if;
  import iase_pkg::*;

  logic       valid;
  logic       ready;
  char_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface iase_result_if;
  import iase_pkg::*;

  logic         valid;
  logic         ready;
  result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/infix_add_sub_evaluator_unit.sv -----
// infix add/sub evaluator: two-stack sequencer with a shared adder
//
//  channel   | dir | payload                    | transaction
//  ----------+-----+----------------------------+--------------------------
//  char_i    | in  | character[7:0], last       | one expression character
//  result_o  | out | value[31:0] signed, error  | one per expression
//
// a digit or ignored character passes Fin, Min, Char and End before ready; '+', ')' and
// a binary '-' add RdOpr and Exit, and ChkOpr when an open parenthesis stops the reduce;
// an operator applied adds RdOpr, ChkOpr, Apply, ApplyB, ApplyA, one dropped stops at Apply;
// the last character adds LMin, RdOpr, Exit, Res, Out, and RdOpr, ChkOpr per open popped
// reset is asynchronous, active low; stack memories are not cleared
// a stalled result holds the output register; a second one waits in readout until taken
module infix_add_sub_evaluator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  iase_char_if.sink     char_i,
  iase_result_if.source result_o
);
  import iase_pkg::*;

  localparam int unsigned ProdW = ValueWidth + 4;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StFin    = 4'd1;
  localparam logic [3:0] StMin    = 4'd2;
  localparam logic [3:0] StChar   = 4'd3;
  localparam logic [3:0] StRdOpr  = 4'd4;
  localparam logic [3:0] StChkOpr = 4'd5;
  localparam logic [3:0] StApply  = 4'd6;
  localparam logic [3:0] StApplyB = 4'd7;
  localparam logic [3:0] StApplyA = 4'd8;
  localparam logic [3:0] StExit   = 4'd9;
  localparam logic [3:0] StEnd    = 4'd10;
  localparam logic [3:0] StLMin   = 4'd11;
  localparam logic [3:0] StRes    = 4'd12;
  localparam logic [3:0] StOut    = 4'd13;

  localparam logic [2:0] KindSub     = 3'd0;
  localparam logic [2:0] KindAdd     = 3'd1;
  localparam logic [2:0] KindClose   = 3'd2;
  localparam logic [2:0] KindLastSub = 3'd3;
  localparam logic [2:0] KindDrain   = 3'd4;

  function automatic err_t keep_first(err_t cur, err_t e);
    return (cur == ErrNone) ? e : cur;
  endfunction

  logic [3:0]            state_q, state_d;
  logic [2:0]            kind_q, kind_d;
  char_t                 ch_q, ch_d;
  logic                  last_q, last_d;
  logic [CountW-1:0]     opnd_cnt_q, opnd_cnt_d;
  logic [CountW-1:0]     opr_cnt_q, opr_cnt_d;
  logic [ValueWidth-1:0] num_q, num_d;
  logic                  in_num_q, in_num_d;
  logic                  neg_q, neg_d;
  logic                  pend_q, pend_d;
  class_t                before_q, before_d;
  class_t                prev_q, prev_d;
  err_t                  err_q, err_d;
  op_t                   opcode_q, opcode_d;
  logic [ValueWidth-1:0] b_q, b_d;
  logic                  res_valid_q, res_valid_d;
  result_item_t          res_q, res_d;

  logic [ValueWidth-1:0] opnd_mem [StackDepth];
  op_t                   opr_mem [StackDepth];
  logic [ValueWidth-1:0] opnd_rd_q;
  op_t                   opr_rd_q;

  logic                  opnd_we, opr_we;
  logic [AddrW-1:0]      opnd_waddr, opnd_raddr, opr_waddr;
  logic [ValueWidth-1:0] opnd_wdata;
  op_t                   opr_wdata;

  logic [CountW-1:0]     opnd_cnt_m1, opnd_cnt_m2, opr_cnt_m1;
  logic                  opnd_full, opr_full, is_digit;
  logic [ProdW-1:0]      num_x10, num_next, num_limit;
  logic [ValueWidth-1:0] num_signed, alu_out;

  assign opnd_cnt_m1 = opnd_cnt_q - CountW'(1);
  assign opnd_cnt_m2 = opnd_cnt_q - CountW'(2);
  assign opr_cnt_m1  = opr_cnt_q - CountW'(1);
  assign opnd_full   = opnd_cnt_q >= CountW'(StackDepth);
  assign opr_full    = opr_cnt_q >= CountW'(StackDepth);
  assign is_digit    = (ch_q >= ChZero) && (ch_q <= ChNine);

  assign num_x10    = (ProdW'(num_q) << 3) + (ProdW'(num_q) << 1);
  assign num_next   = num_x10 + ProdW'(ch_q[3:0]);
  assign num_limit  = neg_q ? ProdW'(VSign) : ProdW'(VMax);
  assign num_signed = neg_q ? (ValueWidth'(0) - num_q) : num_q;
  assign alu_out    = (opcode_q == OpAdd) ? (opnd_rd_q + b_q) : (opnd_rd_q - b_q);

  assign char_i.ready   = (state_q == StIdle);
  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    ch_d        = ch_q;
    last_d      = last_q;
    opnd_cnt_d  = opnd_cnt_q;
    opr_cnt_d   = opr_cnt_q;
    num_d       = num_q;
    in_num_d    = in_num_q;
    neg_d       = neg_q;
    pend_d      = pend_q;
    before_d    = before_q;
    prev_d      = prev_q;
    err_d       = err_q;
    opcode_d    = opcode_q;
    b_d         = b_q;
    res_valid_d = res_valid_q && !result_o.ready;
    res_d       = res_q;
    opnd_we     = 1'b0;
    opnd_waddr  = opnd_cnt_q[AddrW-1:0];
    opnd_wdata  = num_signed;
    opnd_raddr  = opnd_cnt_m1[AddrW-1:0];
    opr_we      = 1'b0;
    opr_waddr   = opr_cnt_q[AddrW-1:0];
    opr_wdata   = OpOpen;

    unique case (state_q)
      StIdle: begin
        if (char_i.valid) begin
          ch_d    = char_i.data.character;
          last_d  = char_i.data.last;
          state_d = StFin;
        end
      end
      StFin: begin
        if (!is_digit && in_num_q) begin
          if (opnd_full) begin
            err_d = keep_first(err_q, ErrOverflow);
          end else begin
            opnd_we    = 1'b1;
            opnd_cnt_d = opnd_cnt_q + CountW'(1);
          end
          in_num_d = 1'b0;
          neg_d    = 1'b0;
          num_d    = '0;
        end
        state_d = StMin;
      end
      StMin: begin
        state_d = StChar;
        if (pend_q) begin
          pend_d = 1'b0;
          if ((before_q == ClsStart) || ((before_q == ClsOther) && is_digit)) begin
            neg_d = ~neg_q;
          end else begin
            kind_d  = KindSub;
            state_d = StRdOpr;
          end
        end
      end
      StChar: begin
        state_d = StEnd;
        prev_d  = ClsOther;
        if (is_digit) begin
          in_num_d = 1'b1;
          prev_d   = ClsDigit;
          if (num_next > num_limit) begin
            num_d = num_limit[ValueWidth-1:0];
            err_d = keep_first(err_q, ErrNumber);
          end else begin
            num_d = num_next[ValueWidth-1:0];
          end
        end else begin
          case (ch_q) inside
            ChOpen: begin
              prev_d = ClsParen;
              if (opr_full) begin
                err_d = keep_first(err_q, ErrOverflow);
              end else begin
                opr_we    = 1'b1;
                opr_wdata = OpOpen;
                opr_cnt_d = opr_cnt_q + CountW'(1);
              end
            end
            ChClose: begin
              prev_d  = ClsParen;
              kind_d  = KindClose;
              state_d = StRdOpr;
            end
            ChMinus: begin
              pend_d   = 1'b1;
              before_d = prev_q;
            end
            ChPlus: begin
              kind_d  = KindAdd;
              state_d = StRdOpr;
            end
            ChTimes, ChSlash: begin
              err_d = keep_first(err_q, ErrMulDiv);
            end
            default: begin
            end
          endcase
        end
      end
      StRdOpr: begin
        state_d = (opr_cnt_q == '0) ? StExit : StChkOpr;
      end
      StChkOpr: begin
        if (kind_q == KindDrain) begin
          opr_cnt_d = opr_cnt_m1;
          opcode_d  = opr_rd_q;
          state_d   = (opr_rd_q == OpOpen) ? StRdOpr : StApply;
        end else if (opr_rd_q == OpOpen) begin
          state_d = StExit;
        end else begin
          opr_cnt_d = opr_cnt_m1;
          opcode_d  = opr_rd_q;
          state_d   = StApply;
        end
      end
      StApply: begin
        if (opnd_cnt_q < CountW'(2)) begin
          err_d   = keep_first(err_q, ErrUnderflow);
          state_d = StRdOpr;
        end else begin
          state_d = StApplyB;
        end
      end
      StApplyB: begin
        b_d        = opnd_rd_q;
        opnd_raddr = opnd_cnt_m2[AddrW-1:0];
        state_d    = StApplyA;
      end
      StApplyA: begin
        opnd_we    = 1'b1;
        opnd_waddr = opnd_cnt_m2[AddrW-1:0];
        opnd_wdata = alu_out;
        opnd_cnt_d = opnd_cnt_m1;
        state_d    = StRdOpr;
      end
      StExit: begin
        unique case (kind_q) inside
          KindSub, KindAdd, KindLastSub: begin
            if (opr_full) begin
              err_d = keep_first(err_q, ErrOverflow);
            end else begin
              opr_we    = 1'b1;
              opr_wdata = (kind_q == KindAdd) ? OpAdd : OpSub;
              opr_cnt_d = opr_cnt_q + CountW'(1);
            end
            if (kind_q == KindSub) begin
              state_d = StChar;
            end else if (kind_q == KindAdd) begin
              state_d = StEnd;
            end else begin
              kind_d  = KindDrain;
              state_d = StRdOpr;
            end
          end
          KindClose: begin
            if (opr_cnt_q == '0) begin
              err_d = keep_first(err_q, ErrUnmatched);
            end else begin
              opr_cnt_d = opr_cnt_m1;
            end
            state_d = StEnd;
          end
          default: begin
            state_d = StRes;
          end
        endcase
      end
      StEnd: begin
        if (!last_q) begin
          state_d = StIdle;
        end else begin
          if (in_num_q) begin
            if (opnd_full) begin
              err_d = keep_first(err_q, ErrOverflow);
            end else begin
              opnd_we    = 1'b1;
              opnd_cnt_d = opnd_cnt_q + CountW'(1);
            end
            in_num_d = 1'b0;
            neg_d    = 1'b0;
            num_d    = '0;
          end
          state_d = StLMin;
        end
      end
      StLMin: begin
        kind_d  = KindDrain;
        state_d = StRdOpr;
        if (pend_q) begin
          pend_d = 1'b0;
          if (before_q == ClsStart) begin
            neg_d = ~neg_q;
          end else begin
            kind_d = KindLastSub;
          end
        end
      end
      StRes: begin
        state_d = StOut;
      end
      StOut: begin
        if (!res_valid_q || result_o.ready) begin
          res_valid_d = 1'b1;
          if (opnd_cnt_q == '0) begin
            res_d.value = '0;
            res_d.error = keep_first(err_q, ErrUnderflow);
          end else begin
            res_d.value = OutValueW'(signed'(opnd_rd_q));
            res_d.error = err_q;
          end
          opnd_cnt_d = '0;
          opr_cnt_d  = '0;
          num_d      = '0;
          in_num_d   = 1'b0;
          neg_d      = 1'b0;
          pend_d     = 1'b0;
          before_d   = ClsStart;
          prev_d     = ClsStart;
          err_d      = ErrNone;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (opnd_we) begin
      opnd_mem[opnd_waddr] <= opnd_wdata;
    end
    opnd_rd_q <= opnd_mem[opnd_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (opr_we) begin
      opr_mem[opr_waddr] <= opr_wdata;
    end
    opr_rd_q <= opr_mem[opr_cnt_m1[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      kind_q      <= KindDrain;
      opnd_cnt_q  <= '0;
      opr_cnt_q   <= '0;
      num_q       <= '0;
      in_num_q    <= 1'b0;
      neg_q       <= 1'b0;
      pend_q      <= 1'b0;
      before_q    <= ClsStart;
      prev_q      <= ClsStart;
      err_q       <= ErrNone;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      opnd_cnt_q  <= opnd_cnt_d;
      opr_cnt_q   <= opr_cnt_d;
      num_q       <= num_d;
      in_num_q    <= in_num_d;
      neg_q       <= neg_d;
      pend_q      <= pend_d;
      before_q    <= before_d;
      prev_q      <= prev_d;
      err_q       <= err_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    last_q   <= last_d;
    opcode_q <= opcode_d;
    b_q      <= b_d;
    res_q    <= res_d;
  end

endmodule

// ----- rtl/iase_checker.sv -----
// port-level assertions for the infix add/sub evaluator, with bind
module iase_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   char_valid_i,
  input logic                   char_ready_i,
  input logic                   result_valid_i,
  input logic                   result_ready_i,
  input iase_pkg::result_item_t result_data_i
);
  import iase_pkg::*;

  // error code stays within the defined set
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> (result_data_i.error <= ErrNumber))
    else $error("result error code out of range");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_i && !result_ready_i) |=> (result_valid_i && $stable(result_data_i)))
    else $error("stalled result changed or dropped");

  // each character transaction keeps the sequencer busy
  a_busy_after_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_i && char_ready_i) |=> !char_ready_i)
    else $error("ready right after a character transaction");

  // a new result is loaded only from the busy readout step
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_i) |-> !$past(char_ready_i))
    else $error("result appeared while idle");

endmodule

bind infix_add_sub_evaluator_unit iase_checker u_iase_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .char_valid_i   (char_i.valid),
  .char_ready_i   (char_i.ready),
  .result_valid_i (result_o.valid),
  .result_ready_i (result_o.ready),
  .result_data_i  (result_o.data)
);
